### rtl/oale_pkg.sv
// shared types, codes and constants for the ordered array-list engine
package oale_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int MAX_RESULTS      = 16;
  localparam int RW               = $clog2(MAX_RESULTS + 1);

  // operation codes carried in func
  localparam logic [2:0] FN_CLEAR   = 3'd0;
  localparam logic [2:0] FN_INSERT  = 3'd1;
  localparam logic [2:0] FN_DELETE  = 3'd2;
  localparam logic [2:0] FN_UPDATE  = 3'd3;
  localparam logic [2:0] FN_SEARCH  = 3'd4;
  localparam logic [2:0] FN_DISPLAY = 3'd5;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_BADLOC   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [2:0]         func;
    logic [3:0]         location;
    logic signed [31:0] value;
    logic signed [31:0] new_value;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         out_location;
    logic signed [31:0] out_data;
    logic               last;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_REPLY,
    S_INS_SHIFT,
    S_INS_WRITE,
    S_DEL_READ,
    S_DEL_SHIFT,
    S_DEL_REPLY,
    S_UPD_SCAN,
    S_SRCH_COUNT,
    S_SRCH_CHECK,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_LOC,
    IDX_LAST,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_UP,
    WR_DOWN,
    WR_VAL,
    WR_NEW
  } wr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLEAR,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [1:0] {
    TL_HOLD,
    TL_ZERO,
    TL_COUNT,
    TL_DISP
  } tally_op_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_STATUS,
    RES_INS,
    RES_DEL,
    RES_UPD,
    RES_ITEM
  } res_op_t;

  typedef struct packed {
    logic       latch;
    idx_op_t    idx_op;
    wr_op_t     wr_op;
    cnt_op_t    cnt_op;
    tally_op_t  tally_op;
    logic       k_clr;
    logic       k_inc;
    logic       save_removed;
    res_op_t    res_op;
    logic [2:0] reply;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       full;
    logic       empty;
    logic       ins_bad;
    logic       ins_at_end;
    logic       del_bad;
    logic       match;
    logic       idx_at_loc;
    logic       idx_more;
    logic       tally_zero;
    logic       item_last;
    logic       out_free;
  } sts_t;

endpackage

### rtl/oale_dpath.sv
// datapath: list memory, count, scan index, tallies and result register
module oale_dpath import oale_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = CW + 4;

  logic [2:0]    func;
  logic [3:0]    loc;
  logic [31:0]   value;
  logic [31:0]   new_value;
  logic [31:0]   removed;
  logic [AW-1:0] idx;
  logic [AW-1:0] idx_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_m1;
  logic [RW-1:0] tally;
  logic [RW-1:0] k;
  logic [31:0]   rdata;
  logic [31:0]   mem [CAPACITY];

  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;

  logic [XW-1:0] loc_x;
  logic [XW-1:0] count_x;
  logic [XW-1:0] idx_x;
  logic          match;
  logic          item_last;

  assign loc_x     = {{CW{1'b0}}, loc};
  assign count_x   = {4'b0000, count};
  assign idx_x     = {{(XW-AW){1'b0}}, idx};
  assign count_m1  = count - 1'b1;
  assign match     = (rdata == value);
  assign item_last = ((k + 1'b1) == tally);

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func      <= req.func;
      loc       <= req.location;
      value     <= req.value;
      new_value <= req.new_value;
    end
    if (cmd.save_removed) begin
      removed <= rdata;
    end
  end

  // scan index; the memory reads at the next index so rdata tracks mem[idx]
  always_comb begin
    case (cmd.idx_op)
      IDX_HOLD: idx_next = idx;
      IDX_ZERO: idx_next = '0;
      IDX_LOC:  idx_next = loc_x[AW-1:0];
      IDX_LAST: idx_next = count_m1[AW-1:0];
      IDX_INC:  idx_next = idx + 1'b1;
      IDX_DEC:  idx_next = idx - 1'b1;
      default:  idx_next = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
  end

  // memory write port
  always_comb begin
    we    = 1'b1;
    waddr = idx;
    wdata = rdata;
    case (cmd.wr_op)
      WR_NONE: we = 1'b0;
      WR_UP:   waddr = idx + 1'b1;
      WR_DOWN: waddr = idx - 1'b1;
      WR_VAL: begin
        waddr = loc_x[AW-1:0];
        wdata = value;
      end
      WR_NEW:  wdata = new_value;
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[idx_next];
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.cnt_op)
        CNT_HOLD:  count <= count;
        CNT_CLEAR: count <= '0;
        CNT_INC:   count <= count + 1'b1;
        CNT_DEC:   count <= count - 1'b1;
        default:   count <= count;
      endcase
    end
  end

  // match tally and emitted-result counter
  always_ff @(posedge clk) begin
    case (cmd.tally_op)
      TL_HOLD:  tally <= tally;
      TL_ZERO:  tally <= '0;
      TL_COUNT: begin
        if (match && (tally != RW'(MAX_RESULTS))) begin
          tally <= tally + 1'b1;
        end
      end
      TL_DISP: begin
        if (count_x > XW'(MAX_RESULTS)) begin
          tally <= RW'(MAX_RESULTS);
        end else begin
          tally <= count_x[RW-1:0];
        end
      end
      default:  tally <= tally;
    endcase
    if (cmd.k_clr) begin
      k <= '0;
    end else if (cmd.k_inc) begin
      k <= k + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.res_op != RES_NONE) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.res_op)
      RES_NONE: rsp <= rsp;
      RES_STATUS: begin
        rsp.status       <= cmd.reply;
        rsp.out_location <= '0;
        rsp.out_data     <= '0;
        rsp.last         <= 1'b1;
      end
      RES_INS: begin
        rsp.status       <= ST_OK;
        rsp.out_location <= loc;
        rsp.out_data     <= value;
        rsp.last         <= 1'b1;
      end
      RES_DEL: begin
        rsp.status       <= ST_OK;
        rsp.out_location <= loc;
        rsp.out_data     <= removed;
        rsp.last         <= 1'b1;
      end
      RES_UPD: begin
        rsp.status       <= ST_OK;
        rsp.out_location <= idx_x[3:0];
        rsp.out_data     <= new_value;
        rsp.last         <= 1'b1;
      end
      RES_ITEM: begin
        rsp.status       <= ST_OK;
        rsp.out_location <= idx_x[3:0];
        rsp.out_data     <= rdata;
        rsp.last         <= item_last;
      end
      default: rsp <= rsp;
    endcase
  end

  always_comb begin
    sts.func       = func;
    sts.full       = (count_x == XW'(CAPACITY));
    sts.empty      = (count == '0);
    sts.ins_bad    = (loc_x > count_x);
    sts.ins_at_end = (loc_x == count_x);
    sts.del_bad    = (loc_x >= count_x);
    sts.match      = match;
    sts.idx_at_loc = (idx_x == loc_x);
    sts.idx_more   = ((idx_x + XW'(1)) < count_x);
    sts.tally_zero = (tally == '0);
    sts.item_last  = item_last;
    sts.out_free   = !rsp_valid || rsp_ready;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_x <= XW'(CAPACITY))
    else $error("entry count above capacity");
`endif

endmodule

### rtl/oale_ctrl.sv
// controller state machine sequencing each list operation
module oale_ctrl import oale_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t     state;
  state_t     state_next;
  logic [2:0] reply;
  logic [2:0] reply_next;
  logic       hit;

  assign hit = (sts.func == FN_DISPLAY) || sts.match;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      reply <= ST_OK;
    end else begin
      state <= state_next;
      reply <= reply_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    reply_next = reply;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.func)
          FN_CLEAR: begin
            reply_next = ST_OK;
            state_next = S_REPLY;
          end
          FN_INSERT: begin
            if (sts.full) begin
              reply_next = ST_FULL;
              state_next = S_REPLY;
            end else if (sts.ins_bad) begin
              reply_next = ST_BADLOC;
              state_next = S_REPLY;
            end else if (sts.ins_at_end) begin
              state_next = S_INS_WRITE;
            end else begin
              state_next = S_INS_SHIFT;
            end
          end
          FN_DELETE: begin
            if (sts.empty) begin
              reply_next = ST_EMPTY;
              state_next = S_REPLY;
            end else if (sts.del_bad) begin
              reply_next = ST_BADLOC;
              state_next = S_REPLY;
            end else begin
              state_next = S_DEL_READ;
            end
          end
          FN_UPDATE: begin
            if (sts.empty) begin
              reply_next = ST_NOTFOUND;
              state_next = S_REPLY;
            end else begin
              state_next = S_UPD_SCAN;
            end
          end
          FN_SEARCH: begin
            if (sts.empty) begin
              reply_next = ST_EMPTY;
              state_next = S_REPLY;
            end else begin
              state_next = S_SRCH_COUNT;
            end
          end
          FN_DISPLAY: begin
            if (sts.empty) begin
              reply_next = ST_EMPTY;
              state_next = S_REPLY;
            end else begin
              state_next = S_EMIT;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_REPLY, S_INS_WRITE, S_DEL_REPLY: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_INS_SHIFT: begin
        if (sts.idx_at_loc) begin
          state_next = S_INS_WRITE;
        end
      end
      S_DEL_READ: begin
        state_next = sts.idx_more ? S_DEL_SHIFT : S_DEL_REPLY;
      end
      S_DEL_SHIFT: begin
        if (!sts.idx_more) begin
          state_next = S_DEL_REPLY;
        end
      end
      S_UPD_SCAN: begin
        if (sts.match) begin
          if (sts.out_free) begin
            state_next = S_IDLE;
          end
        end else if (!sts.idx_more) begin
          reply_next = ST_NOTFOUND;
          state_next = S_REPLY;
        end
      end
      S_SRCH_COUNT: begin
        if (!sts.idx_more) begin
          state_next = S_SRCH_CHECK;
        end
      end
      S_SRCH_CHECK: begin
        if (sts.tally_zero) begin
          reply_next = ST_NOTFOUND;
          state_next = S_REPLY;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (hit && sts.out_free && sts.item_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd           = '0;
    cmd.idx_op    = IDX_HOLD;
    cmd.wr_op     = WR_NONE;
    cmd.cnt_op    = CNT_HOLD;
    cmd.tally_op  = TL_HOLD;
    cmd.res_op    = RES_NONE;
    cmd.reply     = reply;
    req_ready     = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        cmd.latch = req_valid;
      end
      S_DISPATCH: begin
        case (sts.func)
          FN_CLEAR: cmd.cnt_op = CNT_CLEAR;
          FN_INSERT: begin
            if (!sts.full && !sts.ins_bad && !sts.ins_at_end) begin
              cmd.idx_op = IDX_LAST;
            end
          end
          FN_DELETE: begin
            if (!sts.empty && !sts.del_bad) begin
              cmd.idx_op = IDX_LOC;
            end
          end
          FN_UPDATE: begin
            if (!sts.empty) begin
              cmd.idx_op = IDX_ZERO;
            end
          end
          FN_SEARCH: begin
            if (!sts.empty) begin
              cmd.idx_op   = IDX_ZERO;
              cmd.tally_op = TL_ZERO;
            end
          end
          FN_DISPLAY: begin
            if (!sts.empty) begin
              cmd.idx_op   = IDX_ZERO;
              cmd.tally_op = TL_DISP;
              cmd.k_clr    = 1'b1;
            end
          end
          default: cmd.idx_op = IDX_HOLD;
        endcase
      end
      S_REPLY: begin
        if (sts.out_free) begin
          cmd.res_op = RES_STATUS;
        end
      end
      S_INS_SHIFT: begin
        cmd.wr_op = WR_UP;
        if (!sts.idx_at_loc) begin
          cmd.idx_op = IDX_DEC;
        end
      end
      S_INS_WRITE: begin
        if (sts.out_free) begin
          cmd.wr_op  = WR_VAL;
          cmd.cnt_op = CNT_INC;
          cmd.res_op = RES_INS;
        end
      end
      S_DEL_READ: begin
        cmd.save_removed = 1'b1;
        if (sts.idx_more) begin
          cmd.idx_op = IDX_INC;
        end
      end
      S_DEL_SHIFT: begin
        cmd.wr_op = WR_DOWN;
        if (sts.idx_more) begin
          cmd.idx_op = IDX_INC;
        end
      end
      S_DEL_REPLY: begin
        if (sts.out_free) begin
          cmd.cnt_op = CNT_DEC;
          cmd.res_op = RES_DEL;
        end
      end
      S_UPD_SCAN: begin
        if (sts.match) begin
          if (sts.out_free) begin
            cmd.wr_op  = WR_NEW;
            cmd.res_op = RES_UPD;
          end
        end else if (sts.idx_more) begin
          cmd.idx_op = IDX_INC;
        end
      end
      S_SRCH_COUNT: begin
        cmd.tally_op = TL_COUNT;
        if (sts.idx_more) begin
          cmd.idx_op = IDX_INC;
        end else begin
          cmd.idx_op = IDX_ZERO;
          cmd.k_clr  = 1'b1;
        end
      end
      S_SRCH_CHECK: begin
        cmd.idx_op = IDX_HOLD;
      end
      S_EMIT: begin
        if (hit) begin
          if (sts.out_free) begin
            cmd.res_op = RES_ITEM;
            cmd.k_inc  = 1'b1;
            if (!sts.item_last) begin
              cmd.idx_op = IDX_INC;
            end
          end
        end else begin
          cmd.idx_op = IDX_INC;
        end
      end
      default: cmd.idx_op = IDX_HOLD;
    endcase
  end

`ifndef SYNTHESIS
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (cmd.wr_op == WR_NONE && cmd.cnt_op == CNT_HOLD))
    else $error("list state changed while idle");
  a_res_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.res_op != RES_NONE) |-> sts.out_free)
    else $error("result loaded over an untaken result");
  a_shift_up: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_op == WR_UP) |-> (sts.func == FN_INSERT && !sts.full))
    else $error("upward shift outside a legal insert");
`endif

endmodule

### rtl/ordered_array_list_engine_core.sv
// ordered array-list engine top level: controller plus list datapath
// throughput: one request at a time, one entry moved or examined per cycle unless a result
//   waits for the output; next request taken in the cycle after the last result is loaded
// reset: count cleared, controller idle, result register empty; list contents undefined
module ordered_array_list_engine_core import oale_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic clk,
  input  logic rst,
  // request channel
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  // result channel
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  // command and status between controller and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: dispatches on func; shifts, scans one entry a cycle unless a result waits
  oale_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // list memory, count, scan index, match tally and output register
  oale_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

### tb/sv/testbench.sv
// self-checking testbench for the ordered array-list engine core
`timescale 1ns / 1ps

module testbench;
  import oale_pkg::*;

  localparam int CAP          = DEFAULT_CAPACITY;
  localparam int HOLD_CYCLES  = 300;     // long result-side hold-off
  localparam int SETTLE       = 40;      // covers the slowest search on a full list
  localparam int CYCLE_LIMIT  = 600_000;
  localparam int RANDOM_PER_PHASE = 125;

  // func codes the block must ignore
  localparam logic [2:0] FN_SPARE_A = 3'd6;
  localparam logic [2:0] FN_SPARE_B = 3'd7;

  localparam logic signed [31:0] VAL_MAX  = 32'sh7fff_ffff;
  localparam logic signed [31:0] VAL_MIN  = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_FILL = 32'sh5a5a_0f0f;

  // one row of the directed table; want is used only when known is set
  typedef struct {
    req_t r;
    bit   known;
    rsp_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // list mirror and the results still owed by the block
  logic signed [31:0] list_mirror [CAP];
  int   list_len = 0;
  rsp_t op_results [$];
  rsp_t awaited [$];
  plan_row_t plan [$];

  int  mismatches = 0;
  int  cycle_count = 0;
  int  send_gap_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_now = 1'b0;

  always #2 clk = ~clk;

  ordered_array_list_engine_core #(.CAPACITY(CAP)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want);
  endtask

  function automatic void emit(logic [2:0] st, int loc, logic signed [31:0] data, bit fin);
    rsp_t x;
    x.status       = st;
    x.out_location = loc[3:0];
    x.out_data     = data;
    x.last         = fin;
    op_results.push_back(x);
  endfunction

  // applies one request to the mirror and lists the results it causes
  task automatic apply_list_op(input req_t r);
    int i;
    int loc;
    int hits;
    int total;
    int k;
    bit found;
    op_results.delete();
    loc = int'(r.location);
    case (r.func)
      FN_CLEAR: begin
        list_len = 0;
        emit(ST_OK, 0, 0, 1'b1);
      end
      FN_INSERT: begin
        if (list_len >= CAP) emit(ST_FULL, 0, 0, 1'b1);
        else if (loc > list_len) emit(ST_BADLOC, 0, 0, 1'b1);
        else begin
          for (i = list_len; i > loc; i--) list_mirror[i] = list_mirror[i - 1];
          list_mirror[loc] = r.value;
          list_len++;
          emit(ST_OK, loc, r.value, 1'b1);
        end
      end
      FN_DELETE: begin
        if (list_len == 0) emit(ST_EMPTY, 0, 0, 1'b1);
        else if (loc >= list_len) emit(ST_BADLOC, 0, 0, 1'b1);
        else begin
          emit(ST_OK, loc, list_mirror[loc], 1'b1);
          for (i = loc; i + 1 < list_len; i++) list_mirror[i] = list_mirror[i + 1];
          list_len--;
        end
      end
      FN_UPDATE: begin
        found = 1'b0;
        for (i = 0; i < list_len && !found; i++) begin
          if (list_mirror[i] == r.value) begin
            list_mirror[i] = r.new_value;
            emit(ST_OK, i, r.new_value, 1'b1);
            found = 1'b1;
          end
        end
        if (!found) emit(ST_NOTFOUND, 0, 0, 1'b1);
      end
      FN_SEARCH: begin
        hits = 0;
        for (i = 0; i < list_len; i++) if (list_mirror[i] == r.value) hits++;
        if (list_len == 0) emit(ST_EMPTY, 0, 0, 1'b1);
        else if (hits == 0) emit(ST_NOTFOUND, 0, 0, 1'b1);
        else begin
          total = (hits > MAX_RESULTS) ? MAX_RESULTS : hits;
          k = 0;
          for (i = 0; i < list_len && k < total; i++) begin
            if (list_mirror[i] == r.value) begin
              emit(ST_OK, i, list_mirror[i], k + 1 == total);
              k++;
            end
          end
        end
      end
      FN_DISPLAY: begin
        if (list_len == 0) emit(ST_EMPTY, 0, 0, 1'b1);
        else begin
          total = (list_len > MAX_RESULTS) ? MAX_RESULTS : list_len;
          for (i = 0; i < total; i++) emit(ST_OK, i, list_mirror[i], i + 1 == total);
        end
      end
      default: ;  // spare codes: no result, no change
    endcase
  endtask

  function automatic void plan_step(logic [2:0] fn, logic [3:0] loc,
                                    logic signed [31:0] val, logic signed [31:0] nval);
    plan_row_t row;
    row.r.func      = fn;
    row.r.location  = loc;
    row.r.value     = val;
    row.r.new_value = nval;
    row.known       = 1'b0;
    row.want        = '0;
    plan.push_back(row);
  endfunction

  // row whose single result is typed in directly
  function automatic void plan_known(logic [2:0] fn, logic [3:0] loc,
                                     logic signed [31:0] val, logic signed [31:0] nval,
                                     logic [2:0] st, logic [3:0] oloc,
                                     logic signed [31:0] odata);
    plan_step(fn, loc, val, nval);
    plan[$].known              = 1'b1;
    plan[$].want.status        = st;
    plan[$].want.out_location  = oloc;
    plan[$].want.out_data      = odata;
    plan[$].want.last          = 1'b1;
  endfunction

  // one request: optional idle gap, hold valid until accepted, then predict
  task automatic offer(input req_t r, input bit known, input rsp_t want);
    while ($urandom_range(99) < send_gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    apply_list_op(r);
    if (known) begin
      op_results.delete();
      op_results.push_back(want);
    end
    foreach (op_results[i]) awaited.push_back(op_results[i]);
  endtask

  // sender pause until every owed result is back
  task automatic drain();
    req_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // mostly small repeating values so search and update find matches
  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return sel - 1;
    if (sel == 6) return VAL_MAX;
    if (sel == 7) return VAL_MIN;
    return $urandom;
  endfunction

  // random request shaped by the current list length
  task automatic make_random_op(output req_t r);
    int pick;
    int top;
    pick = $urandom_range(99);
    r.location  = 4'($urandom_range(0, 15));
    r.value     = pick_value();
    r.new_value = ($urandom_range(99) < 25) ? pick_value() : $signed($urandom);
    top = (list_len > 15) ? 15 : list_len;
    if (pick < 34) begin
      r.func = FN_INSERT;
      if ($urandom_range(99) < 90) r.location = 4'($urandom_range(0, top));
    end else if (pick < 58) begin
      r.func = FN_DELETE;
      if (list_len > 0 && $urandom_range(99) < 85)
        r.location = 4'($urandom_range(0, list_len - 1));
    end else if (pick < 70) r.func = FN_UPDATE;
    else if (pick < 82) r.func = FN_SEARCH;
    else if (pick < 92) r.func = FN_DISPLAY;
    else if (pick < 95) r.func = FN_CLEAR;
    else r.func = (pick < 98) ? FN_SPARE_A : FN_SPARE_B;
  endtask

  // random requests; spare codes do not count toward the quota
  task automatic run_random(int quota, int hold_at);
    int n;
    req_t r;
    n = 0;
    while (n < quota) begin
      make_random_op(r);
      if (n == hold_at) hold_now = 1'b1;
      offer(r, 1'b0, '0);
      if (r.func <= FN_DISPLAY) n++;
    end
  endtask

  // result side: random stalls, or a long hold-off counted here
  always begin
    @(posedge clk);
    if (hold_now) begin
      hold_now = 1'b0;
      rsp_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker: oldest owed result against each accepted one
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (awaited.size() == 0) begin
        report_mismatch("result with nothing outstanding, data",
                        longint'(rsp.out_data), 0);
      end else begin
        want = awaited.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", longint'(rsp.status), longint'(want.status));
        if (rsp.out_location !== want.out_location)
          report_mismatch("out_location", longint'(rsp.out_location),
                          longint'(want.out_location));
        if (rsp.out_data !== want.out_data)
          report_mismatch("out_data", longint'(rsp.out_data), longint'(want.out_data));
        if (rsp.last !== want.last)
          report_mismatch("last", longint'(rsp.last), longint'(want.last));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int i;
    // empty-list cases and the ignored codes
    plan_known(FN_DISPLAY, 0, 0, 0, ST_EMPTY, 0, 0);
    plan_known(FN_SEARCH, 0, 7, 0, ST_EMPTY, 0, 0);
    plan_known(FN_UPDATE, 0, 7, 9, ST_NOTFOUND, 0, 0);
    plan_known(FN_DELETE, 0, 0, 0, ST_EMPTY, 0, 0);
    plan_known(FN_INSERT, 1, 3, 0, ST_BADLOC, 0, 0);
    plan_step(FN_SPARE_A, 15, -1, -1);
    plan_step(FN_SPARE_B, 0, VAL_MIN, VAL_MAX);
    // extremes of value, insert at head and at the end
    plan_known(FN_INSERT, 0, VAL_MAX, 0, ST_OK, 0, VAL_MAX);
    plan_known(FN_INSERT, 0, VAL_MIN, -1, ST_OK, 0, VAL_MIN);
    plan_known(FN_INSERT, 2, -1, 0, ST_OK, 2, -1);
    plan_known(FN_DELETE, 3, 0, 0, ST_BADLOC, 0, 0);
    plan_known(FN_SEARCH, 0, 12345, 0, ST_NOTFOUND, 0, 0);
    // fill to capacity with one repeated value at scattered places
    for (i = 3; i < CAP; i++)
      plan_step(FN_INSERT, 4'($urandom_range(0, i)), VAL_FILL, $urandom);
    plan_known(FN_INSERT, 0, 1, 0, ST_FULL, 0, 0);
    plan_step(FN_SEARCH, 0, VAL_FILL, 0);
    plan_step(FN_DISPLAY, 0, 0, 0);
    plan_step(FN_UPDATE, 0, VAL_MIN, VAL_MAX);
    plan_step(FN_DELETE, 15, 0, 0);
    plan_step(FN_DELETE, 0, 0, 0);
    plan_known(FN_INSERT, 15, 0, 0, ST_BADLOC, 0, 0);
    plan_known(FN_CLEAR, 0, 0, 0, ST_OK, 0, 0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // phase one: sender gaps 35%, receiver stalls 72%, with one long hold-off
    send_gap_pct   = 35;
    recv_stall_pct = 72;
    foreach (plan[k]) offer(plan[k].r, plan[k].known, plan[k].want);
    run_random(RANDOM_PER_PHASE, 40);

    // phase two: the other way round, starting from a drained block
    drain();
    send_gap_pct   = 72;
    recv_stall_pct = 35;
    run_random(RANDOM_PER_PHASE, -1);

    // phase three: back to back on both sides
    drain();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_random(RANDOM_PER_PHASE, -1);

    req_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
